// ===== rtl/core/cus_pkg.sv =====
// package for the coap uri splitter: parser state, codes and match patterns
package cus_pkg;

    typedef enum logic [3:0] {
        PH_START,
        PH_SCHEME,
        PH_AFTER_CO,
        PH_AFTER_S,
        PH_TCP,
        PH_SEP,
        PH_HOST0,
        PH_HOST,
        PH_V6,
        PH_AFTER_V6,
        PH_PORT,
        PH_PATH,
        PH_QUERY,
        PH_ERROR
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  match_index;
        logic [15:0] port_acc;
        logic        port_seen;
        logic        host_nonempty;
        logic        secure_flag;
        logic        tcp_flag;
        logic [2:0]  error_code;
    } parse_state_t;

    localparam parse_state_t PARSE_CLEAR = '{
        phase:         PH_START,
        match_index:   2'd0,
        port_acc:      16'd0,
        port_seen:     1'b0,
        host_nonempty: 1'b0,
        secure_flag:   1'b0,
        tcp_flag:      1'b0,
        error_code:    3'd0
    };

    // byte classes
    localparam logic [2:0] CLS_NONE   = 3'd0;
    localparam logic [2:0] CLS_SCHEME = 3'd1;
    localparam logic [2:0] CLS_HOST   = 3'd2;
    localparam logic [2:0] CLS_PORT   = 3'd3;
    localparam logic [2:0] CLS_PATH   = 3'd4;
    localparam logic [2:0] CLS_QUERY  = 3'd5;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_SCHEME  = 3'd1;
    localparam logic [2:0] ST_BAD_SEP     = 3'd2;
    localparam logic [2:0] ST_EMPTY_HOST  = 3'd3;
    localparam logic [2:0] ST_PORT_RANGE  = 3'd4;

    // configuration register indexes
    localparam logic REG_PLAIN_PORT  = 1'b0;
    localparam logic REG_SECURE_PORT = 1'b1;

    localparam logic [15:0] PLAIN_PORT_RESET  = 16'd5683;
    localparam logic [15:0] SECURE_PORT_RESET = 16'd5684;

    localparam logic [16:0] PORT_MAX = 17'd65535;

    // case offset between lower and upper ascii letters
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    function automatic logic [7:0] scheme_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = "c";
            2'd1:    ch = "o";
            2'd2:    ch = "a";
            default: ch = "p";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] tcp_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = "t";
            2'd1:    ch = "c";
            default: ch = "p";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] sep_char(input logic [1:0] idx);
        logic [7:0] ch;
        case (idx)
            2'd0:    ch = ":";
            default: ch = "/";
        endcase
        return ch;
    endfunction

    // status a uri gets when it ends in the given phase
    function automatic logic [2:0] end_status(input parse_state_t st);
        logic [2:0] res;
        case (st.phase) inside
            PH_ERROR:                                    res = st.error_code;
            PH_START, PH_SCHEME:                         res = ST_BAD_SCHEME;
            PH_AFTER_CO, PH_AFTER_S, PH_TCP, PH_SEP:     res = ST_BAD_SEP;
            PH_HOST0, PH_V6:                             res = ST_EMPTY_HOST;
            default:                                     res = ST_OK;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/coap_uri_splitter_unit.sv =====
// coap uri splitter: byte classifier with end-of-uri status, port and scheme flags
// each result is registered, in the output register or, while that is held, in the skid entry
// throughput: one byte per clock while the skid entry is empty, set by the single parser register stage
// a two-entry result buffer (output register plus skid) keeps input ready registered
// reset: parser returns to start of uri, result buffer empties, default ports 5683/5684
// configuration writes are always ready and take effect on the next byte
module coap_uri_splitter_unit
    import cus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // input byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  uri_byte,
    input  logic        last_byte,

    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_class,
    output logic        uri_done,
    output logic [2:0]  status,
    output logic [15:0] port_value,
    output logic        secure_scheme,
    output logic        tcp_transport,

    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef struct packed {
        logic [2:0]  byte_class;
        logic        uri_done;
        logic [2:0]  status;
        logic [15:0] port_value;
        logic        secure_scheme;
        logic        tcp_transport;
    } result_t;

    // configuration registers
    logic [15:0] plain_port_reg;
    logic [15:0] secure_port_reg;

    // parser state
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    logic [2:0]   step_class;

    // result buffer
    result_t res_reg;
    result_t skid_reg;
    result_t res_new;
    logic    res_valid_reg;
    logic    skid_valid_reg;

    logic       in_xact;
    logic       out_xact;
    logic [2:0] end_st;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plain_port_reg  <= PLAIN_PORT_RESET;
            secure_port_reg <= SECURE_PORT_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PLAIN_PORT:  plain_port_reg  <= cfg_data;
                REG_SECURE_PORT: secure_port_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // one parser step per byte
    cus_step u_step (
        .cur        (state_reg),
        .uri_byte   (uri_byte),
        .nxt        (step_state),
        .byte_class (step_class)
    );

    // handshakes: input stalls only when the skid entry is occupied
    assign in_ready = !skid_valid_reg;
    assign in_xact  = in_valid && in_ready;
    assign out_xact = res_valid_reg && out_ready;

    // status as the uri stands after this byte
    assign end_st = end_status(step_state);

    always_comb
    begin
        res_new.byte_class    = step_class;
        res_new.uri_done      = last_byte;
        res_new.status        = ST_OK;
        res_new.port_value    = 16'd0;
        res_new.secure_scheme = 1'b0;
        res_new.tcp_transport = 1'b0;
        if (last_byte)
        begin
            res_new.status        = end_st;
            res_new.secure_scheme = step_state.secure_flag;
            res_new.tcp_transport = step_state.tcp_flag;
            if (end_st == ST_OK)
            begin
                if (step_state.port_seen)
                    res_new.port_value = step_state.port_acc;
                else if (step_state.secure_flag)
                    res_new.port_value = secure_port_reg;
                else
                    res_new.port_value = plain_port_reg;
            end
        end
    end

    // parser state clears after the last byte of each uri
    always_comb
    begin
        state_next = state_reg;
        if (in_xact)
            state_next = last_byte ? PARSE_CLEAR : step_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= PARSE_CLEAR;
        else
            state_reg <= state_next;
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_xact)
                skid_valid_reg <= 1'b0;
        end
        else if (in_xact)
        begin
            if (res_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                res_valid_reg <= 1'b1;
        end
        else if (out_xact)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_xact)
                res_reg <= skid_reg;
        end
        else if (in_xact)
        begin
            if (res_valid_reg && !out_ready)
                skid_reg <= res_new;
            else
                res_reg <= res_new;
        end
    end

    assign out_valid     = res_valid_reg;
    assign byte_class    = res_reg.byte_class;
    assign uri_done      = res_reg.uri_done;
    assign status        = res_reg.status;
    assign port_value    = res_reg.port_value;
    assign secure_scheme = res_reg.secure_scheme;
    assign tcp_transport = res_reg.tcp_transport;

endmodule

// ===== rtl/core/cus_step.sv =====
// per-byte parser step: next parser state and byte class
module cus_step
    import cus_pkg::*;
(
    input  parse_state_t cur,
    input  logic [7:0]   uri_byte,
    output parse_state_t nxt,
    output logic [2:0]   byte_class
);

    logic [1:0]  mi_eff;
    logic [7:0]  pat;
    logic [19:0] port_sum;
    logic        is_digit;

    assign mi_eff   = (cur.phase == PH_START) ? 2'd0 : cur.match_index;
    assign pat      = scheme_char(mi_eff);
    assign is_digit = (uri_byte >= "0") && (uri_byte <= "9");
    assign port_sum = ({4'd0, cur.port_acc} << 3) + ({4'd0, cur.port_acc} << 1)
                    + {16'd0, uri_byte[3:0]};

    // next parser state
    always_comb
    begin
        nxt = cur;
        unique case (cur.phase) inside
            PH_START, PH_SCHEME:
            begin
                if (cur.phase == PH_START && uri_byte == "/")
                begin
                    nxt.phase = PH_PATH;
                end
                else if (uri_byte == pat || uri_byte == pat - CASE_OFFSET)
                begin
                    nxt.match_index = mi_eff;
                    if (mi_eff == 2'd3)
                    begin
                        nxt.phase = PH_AFTER_CO;
                    end
                    else
                    begin
                        nxt.phase       = PH_SCHEME;
                        nxt.match_index = mi_eff + 2'd1;
                    end
                end
                else
                begin
                    nxt.match_index = mi_eff;
                    nxt.phase       = PH_ERROR;
                    nxt.error_code  = ST_BAD_SCHEME;
                end
            end
            PH_AFTER_CO, PH_AFTER_S:
            begin
                if (uri_byte == "s" && cur.phase == PH_AFTER_CO)
                begin
                    nxt.secure_flag = 1'b1;
                    nxt.phase       = PH_AFTER_S;
                end
                else if (uri_byte == "+")
                begin
                    nxt.phase       = PH_TCP;
                    nxt.match_index = 2'd0;
                end
                else if (uri_byte == ":")
                begin
                    nxt.phase       = PH_SEP;
                    nxt.match_index = 2'd1;
                end
                else
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_BAD_SEP;
                end
            end
            PH_TCP:
            begin
                if (cur.match_index != 2'd3 && uri_byte == tcp_char(cur.match_index))
                begin
                    if (cur.match_index == 2'd2)
                    begin
                        nxt.tcp_flag    = 1'b1;
                        nxt.phase       = PH_SEP;
                        nxt.match_index = 2'd0;
                    end
                    else
                    begin
                        nxt.match_index = cur.match_index + 2'd1;
                    end
                end
                else
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_BAD_SEP;
                end
            end
            PH_SEP:
            begin
                if (cur.match_index != 2'd3 && uri_byte == sep_char(cur.match_index))
                begin
                    if (cur.match_index == 2'd2)
                    begin
                        nxt.phase = PH_HOST0;
                    end
                    else
                    begin
                        nxt.match_index = cur.match_index + 2'd1;
                    end
                end
                else
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_BAD_SEP;
                end
            end
            PH_HOST0:
            begin
                if (uri_byte == "[")
                begin
                    nxt.phase = PH_V6;
                end
                else if (uri_byte == ":" || uri_byte == "/" || uri_byte == "?")
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_EMPTY_HOST;
                end
                else
                begin
                    nxt.host_nonempty = 1'b1;
                    nxt.phase         = PH_HOST;
                end
            end
            PH_HOST:
            begin
                if (uri_byte == ":")
                begin
                    nxt.phase = PH_PORT;
                end
                else if (uri_byte == "/")
                begin
                    nxt.phase = PH_PATH;
                end
                else if (uri_byte == "?")
                begin
                    nxt.phase = PH_QUERY;
                end
            end
            PH_V6:
            begin
                if (uri_byte == "]")
                begin
                    if (!cur.host_nonempty)
                    begin
                        nxt.phase      = PH_ERROR;
                        nxt.error_code = ST_EMPTY_HOST;
                    end
                    else
                    begin
                        nxt.phase = PH_AFTER_V6;
                    end
                end
                else
                begin
                    nxt.host_nonempty = 1'b1;
                end
            end
            PH_AFTER_V6:
            begin
                if (uri_byte == ":")
                begin
                    nxt.phase = PH_PORT;
                end
                else if (uri_byte == "/")
                begin
                    nxt.phase = PH_PATH;
                end
                else if (uri_byte == "?")
                begin
                    nxt.phase = PH_QUERY;
                end
                else
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_BAD_SCHEME;
                end
            end
            PH_PORT:
            begin
                if (is_digit)
                begin
                    nxt.port_seen = 1'b1;
                    nxt.port_acc  = port_sum[15:0];
                    if (port_sum > {3'd0, PORT_MAX})
                    begin
                        nxt.phase      = PH_ERROR;
                        nxt.error_code = ST_PORT_RANGE;
                    end
                end
                else if (uri_byte == "/")
                begin
                    nxt.phase = PH_PATH;
                end
                else if (uri_byte == "?")
                begin
                    nxt.phase = PH_QUERY;
                end
                else
                begin
                    nxt.phase      = PH_ERROR;
                    nxt.error_code = ST_BAD_SCHEME;
                end
            end
            PH_PATH:
            begin
                if (uri_byte == "?")
                begin
                    nxt.phase = PH_QUERY;
                end
            end
            default:
            begin
                // query and error phases hold until the last byte
            end
        endcase
    end

    // byte class of the current byte
    always_comb
    begin
        byte_class = CLS_NONE;
        unique case (cur.phase) inside
            PH_START, PH_SCHEME:
            begin
                // a leading slash never matches the scheme letter
                if (uri_byte == pat || uri_byte == pat - CASE_OFFSET)
                    byte_class = CLS_SCHEME;
            end
            PH_AFTER_CO, PH_AFTER_S:
            begin
                if ((uri_byte == "s" && cur.phase == PH_AFTER_CO) || uri_byte == "+")
                    byte_class = CLS_SCHEME;
            end
            PH_TCP:
            begin
                if (cur.match_index != 2'd3 && uri_byte == tcp_char(cur.match_index))
                    byte_class = CLS_SCHEME;
            end
            PH_HOST0:
            begin
                if (!(uri_byte == "[" || uri_byte == ":" || uri_byte == "/"
                      || uri_byte == "?"))
                    byte_class = CLS_HOST;
            end
            PH_HOST:
            begin
                if (!(uri_byte == ":" || uri_byte == "/" || uri_byte == "?"))
                    byte_class = CLS_HOST;
            end
            PH_V6:
            begin
                if (uri_byte != "]")
                    byte_class = CLS_HOST;
            end
            PH_PORT:
            begin
                if (is_digit && !(port_sum > {3'd0, PORT_MAX}))
                    byte_class = CLS_PORT;
            end
            PH_PATH:
            begin
                if (uri_byte != "?")
                    byte_class = CLS_PATH;
            end
            PH_QUERY:
            begin
                byte_class = CLS_QUERY;
            end
            default:
            begin
                // separators and error phase carry no class
            end
        endcase
    end

endmodule
